// ===== hw/rtl/tfdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdq_pkg
// Shared types, constants and helpers of the touch frame deframer queue.
// ----------------------------------------------------------------------------
package tfdq_pkg;

    localparam int MAX_FRAME_LEN = 64;
    localparam int QUEUE_DEPTH   = 8;
    localparam int HEAD_KEEP     = 6;

    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_FIRST  = 8'h5A;
    localparam logic [7:0] HDR_SECOND = 8'hA5;
    localparam logic [7:0] CMD_UPLOAD = 8'h83;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        PH_H1   = 2'd0,
        PH_H2   = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [15:0] code;
    } t_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tfdq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdq interfaces
// Input, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tfdq_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface tfdq_out_if;
    logic        valid;
    logic        ready;
    logic        code_valid;
    logic [15:0] touch_code;

    modport source (output valid, code_valid, touch_code, input ready);
    modport sink   (input valid, code_valid, touch_code, output ready);
endinterface

interface tfdq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] touch_vp_address;

    modport source (output valid, touch_vp_address, input ready);
    modport sink   (input valid, touch_vp_address, output ready);
endinterface

// ===== hw/rtl/tfdq_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdq_parser
// Header/length frame parser; flags a touch code to queue at frame end.
// ----------------------------------------------------------------------------
module tfdq_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte_en,
    input  logic [7:0]           i_byte,
    input  logic [15:0]          i_vp_addr,
    output tfdq_pkg::t_push      o_push
);
    import tfdq_pkg::*;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [7:0]       r_head [HEAD_KEEP];
    logic [7:0]       head_eff [HEAD_KEEP];
    logic [HEAD_KEEP-1:0] head_we;
    logic [LEN_W-1:0] idx_inc;
    logic             last_byte;
    logic             data_byte;

    assign idx_inc   = r_idx + 1'b1;
    assign last_byte = (idx_inc >= r_len);
    assign data_byte = i_byte_en && (r_phase == PH_DATA);

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        if (i_byte_en) begin
            case (r_phase)
                PH_H1: begin
                    if (i_byte == HDR_FIRST) n_phase = PH_H2;
                end
                PH_H2: begin
                    if (i_byte == HDR_SECOND) begin
                        n_phase = PH_LEN;
                    end else if (i_byte != HDR_FIRST) begin
                        n_phase = PH_H1;
                    end
                end
                PH_LEN: begin
                    if (i_byte == 8'd0 || i_byte > 8'(MAX_FRAME_LEN)) begin
                        n_phase = PH_H1;
                    end else begin
                        n_len   = i_byte[LEN_W-1:0];
                        n_idx   = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_idx = idx_inc;
                    if (last_byte) n_phase = PH_H1;
                end
                default: n_phase = PH_H1;
            endcase
        end
    end

    // Outputs: head byte capture and the frame check. The byte that arrives
    // now is merged in, since it can itself be the last head byte.
    always_comb begin
        for (int k = 0; k < HEAD_KEEP; k++) begin
            head_we[k]  = data_byte && (r_idx == LEN_W'(k));
            head_eff[k] = head_we[k] ? i_byte : r_head[k];
        end
        o_push.valid = data_byte && last_byte
                    && (r_len >= LEN_W'(HEAD_KEEP))
                    && (head_eff[0] == CMD_UPLOAD)
                    && ({head_eff[1], head_eff[2]} == i_vp_addr)
                    && (head_eff[3] != 8'd0);
        o_push.code  = {head_eff[4], head_eff[5]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H1;
            r_len   <= '0;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HEAD_KEEP; k++) begin
            if (head_we[k]) r_head[k] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/tfdq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdq_queue
// Ring queue of touch codes; one slot stays free to tell full from empty.
// ----------------------------------------------------------------------------
module tfdq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tfdq_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_code_valid,
    output logic [15:0]      o_code
);
    import tfdq_pkg::*;

    logic [15:0]      r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] wp_inc;
    logic             empty;
    logic             push_ok;

    assign wp_inc  = ptr_inc(r_wp);
    assign empty   = (r_wp == r_rp);
    assign push_ok = i_push.valid && (wp_inc != r_rp);

    assign o_code_valid = !empty;
    assign o_code       = empty ? 16'd0 : r_store[r_rp];

    always_comb begin
        n_wp = push_ok ? wp_inc : r_wp;
        n_rp = (i_pop && !empty) ? ptr_inc(r_rp) : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_store[r_wp] <= i_push.code;
    end

endmodule

// ===== hw/rtl/touch_frame_deframer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_frame_deframer_queue
// Serial frame parser that queues touch codes from matching upload frames.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no pop item waits. A byte item
// produces no result; a pop item passes from the input register to the output
// register as soon as the output side has taken any earlier result. The rate is
// set by the single processing stage between the input register and the
// output register, where the parser and the queue each update once a cycle.
// A pop item waits in the input register while an earlier result is still
// held in the output register; byte items behind that waiting pop are held
// back meanwhile.
module touch_frame_deframer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfdq_in_if.sink     i_in,
    tfdq_out_if.source  o_out,
    tfdq_cfg_if.sink    i_cfg
);
    import tfdq_pkg::*;

    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic        r_out_code_valid;
    logic [15:0] r_out_code;
    logic [15:0] r_vp_addr;

    logic        out_free;
    logic        advance;
    logic        byte_en;
    logic        pop_en;
    t_push       push;
    logic        q_code_valid;
    logic [15:0] q_code;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && ((r_in_kind == KIND_BYTE) || out_free);
    assign byte_en  = advance && (r_in_kind == KIND_BYTE);
    assign pop_en   = advance && (r_in_kind == KIND_POP);

    assign i_in.ready       = !r_in_valid || advance;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.code_valid = r_out_code_valid;
    assign o_out.touch_code = r_out_code;

    tfdq_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (r_in_byte),
        .i_vp_addr (r_vp_addr),
        .o_push    (push)
    );

    tfdq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop_en),
        .o_code_valid (q_code_valid),
        .o_code       (q_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vp_addr   <= '0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (pop_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) r_vp_addr <= i_cfg.touch_vp_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_byte <= i_in.rx_byte;
        end
        if (pop_en) begin
            r_out_code_valid <= q_code_valid;
            r_out_code       <= q_code;
        end
    end

endmodule

// ===== hw/rtl/tfdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdq_checker
// Port-level checks of the touch frame deframer queue, bound to the top.
// ----------------------------------------------------------------------------
module tfdq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_kind,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_code_valid,
    input logic [15:0] i_out_touch_code
);
    import tfdq_pkg::*;

    // A held result must not change until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_touch_code)
            && $stable(i_out_code_valid))
        else $error("result changed while stalled");

    // An empty queue answers with a zero code.
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_code_valid |-> i_out_touch_code == 16'd0)
        else $error("nonzero code without valid flag");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // A fresh result comes from a pop transferred into the input register before it.
    a_rose_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready
            && (i_in_kind == KIND_POP), 2))
        else $error("result without a pop transfer");

endmodule

bind touch_frame_deframer_queue tfdq_checker u_tfdq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_kind        (i_in.kind),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_code_valid (o_out.code_valid),
    .i_out_touch_code (o_out.touch_code)
);

// ===== sim/touch_frame_deframer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_frame_deframer_queue_tb
// Self-checking testbench for the touch frame deframer queue. A table of
// directed bytes and pops runs first. Random frames, broken headers, noise
// and pops then run under several touch addresses. Both handshake sides
// idle at random, and the result side holds off once for a long stretch.
// Every pop result is compared with a cycle-free model of the parser and
// the code queue.
// ----------------------------------------------------------------------------
module touch_frame_deframer_queue_tb;
    import tfdq_pkg::*;

    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic        code_valid;
        logic [15:0] touch_code;
    } pop_result_t;

    typedef struct packed {
        logic        typed;
        pop_result_t result;
    } typed_result_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic        typed;
        logic        code_valid;
        logic [15:0] touch_code;
    } stim_row_t;

    // Directed rows: resync on bad lengths, tolerated repeated first header,
    // a matching frame with extreme code, pops on an empty queue and a pop in
    // the middle of a frame.
    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{KIND_POP,  8'h00,      1'b1, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_FIRST,  1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_FIRST,  1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_SECOND, 1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h00,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_FIRST,  1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_SECOND, 1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h41,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_FIRST,  1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_SECOND, 1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h06,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, CMD_UPLOAD, 1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h00,      1'b0, 1'b0, 16'h0000},
        '{KIND_POP,  8'hFF,      1'b1, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h00,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h01,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'hFF,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'hFF,      1'b0, 1'b0, 16'h0000},
        '{KIND_POP,  8'h00,      1'b1, 1'b1, 16'hFFFF},
        '{KIND_POP,  8'h00,      1'b1, 1'b0, 16'h0000},
        '{KIND_BYTE, HDR_FIRST,  1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'h00,      1'b0, 1'b0, 16'h0000},
        '{KIND_BYTE, 8'hFF,      1'b0, 1'b0, 16'h0000},
        '{KIND_POP,  8'h00,      1'b0, 1'b0, 16'h0000}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tfdq_in_if  in_ch();
    tfdq_out_if out_ch();
    tfdq_cfg_if cfg_ch();

    touch_frame_deframer_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    // Model state of the parser and the code queue.
    t_phase           rx_phase = PH_H1;
    logic [LEN_W-1:0] frame_len = '0;
    logic [LEN_W-1:0] payload_idx = '0;
    logic [7:0]       head_bytes [HEAD_KEEP];
    logic [15:0]      code_ring [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [15:0]      vp_addr = 16'h0000;

    pop_result_t   expected_codes [$];
    typed_result_t typed_notes [$];

    int   mismatch_count = 0;
    int   items_sent = 0;
    logic send_no_idle = 1'b0;
    logic recv_no_idle = 1'b0;
    logic hold_request = 1'b0;
    logic [15:0] target_addr = 16'h0000;

    function automatic void apply_rx_byte(input logic [7:0] b);
        logic [PTR_W-1:0] nxt;
        case (rx_phase)
            PH_H1: begin
                if (b == HDR_FIRST) rx_phase = PH_H2;
            end
            PH_H2: begin
                if (b == HDR_SECOND) begin
                    rx_phase = PH_LEN;
                end else if (b != HDR_FIRST) begin
                    rx_phase = PH_H1;
                end
            end
            PH_LEN: begin
                if (b == 8'h00 || int'(b) > MAX_FRAME_LEN) begin
                    rx_phase = PH_H1;
                end else begin
                    frame_len   = LEN_W'(b);
                    payload_idx = '0;
                    rx_phase    = PH_DATA;
                end
            end
            default: begin
                if (int'(payload_idx) < HEAD_KEEP) head_bytes[payload_idx] = b;
                payload_idx = payload_idx + 1'b1;
                if (payload_idx >= frame_len) begin
                    rx_phase = PH_H1;
                    if (int'(frame_len) >= HEAD_KEEP && head_bytes[0] == CMD_UPLOAD &&
                        {head_bytes[1], head_bytes[2]} == vp_addr &&
                        head_bytes[3] != 8'h00) begin
                        // One slot stays free, so a full queue drops the code.
                        nxt = PTR_W'((int'(wr_ptr) + 1) % QUEUE_DEPTH);
                        if (nxt != rd_ptr) begin
                            code_ring[wr_ptr] = {head_bytes[4], head_bytes[5]};
                            wr_ptr = nxt;
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic pop_result_t take_touch_code();
        pop_result_t r;
        if (rd_ptr == wr_ptr) begin
            r = '0;
        end else begin
            r.code_valid = 1'b1;
            r.touch_code = code_ring[rd_ptr];
            rd_ptr = PTR_W'((int'(rd_ptr) + 1) % QUEUE_DEPTH);
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : track_and_check
        typed_result_t note;
        pop_result_t   predicted;
        pop_result_t   got;
        pop_result_t   want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) vp_addr = cfg_ch.touch_vp_address;
            if (in_ch.valid && in_ch.ready) begin
                note = (typed_notes.size() != 0) ? typed_notes.pop_front() : '0;
                if (in_ch.kind == KIND_POP) begin
                    predicted = take_touch_code();
                    expected_codes.push_back(note.typed ? note.result : predicted);
                end else begin
                    apply_rx_byte(in_ch.rx_byte);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.code_valid, out_ch.touch_code};
                if (expected_codes.size() == 0) begin
                    report_failure($sformatf("unexpected result: code_valid %0b code %04h",
                                             got.code_valid, got.touch_code));
                end else begin
                    want = expected_codes.pop_front();
                    if (got != want) begin
                        report_failure($sformatf(
                            "result mismatch: code_valid exp %0b got %0b, code exp %04h got %04h",
                            want.code_valid, got.code_valid, want.touch_code,
                            got.touch_code));
                    end
                end
            end
        end
    end

    // Result side: random hold-offs per result, and one long hold on request.
    initial begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = recv_no_idle ? 0 : $urandom_range(0, 8);
            end
            @(negedge i_clk);
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_item(input logic k, input logic [7:0] b, input typed_result_t note);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.kind    = k;
        in_ch.rx_byte = b;
        in_ch.valid   = 1'b1;
        typed_notes.push_back(note);
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(KIND_BYTE, b, '0);
    endtask

    task automatic send_pop();
        send_item(KIND_POP, 8'($urandom), '0);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [15:0] addr);
        @(negedge i_clk);
        cfg_ch.touch_vp_address = addr;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        target_addr = addr;
    endtask

    // Well-formed frames with random content, mixed with broken
    // headers, truncated frames, noise bytes and pops.
    task automatic run_phase(input int count, input int pop_pct);
        int stop_at;
        int pick;
        int len;
        int k;
        logic [7:0]  body [HEAD_KEEP];
        logic [15:0] addr;
        logic [7:0]  b;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                send_no_idle = ($urandom_range(0, 3) == 0);
                recv_no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < pop_pct) begin
                send_pop();
            end else if (pick < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len = $urandom_range(HEAD_KEEP, 9);
                else if (pick < 80) len = $urandom_range(10, MAX_FRAME_LEN);
                else if (pick < 90) len = $urandom_range(1, HEAD_KEEP - 1);
                else len = (pick < 95) ? MAX_FRAME_LEN : HEAD_KEEP;
                addr = ($urandom_range(0, 99) < 85) ? target_addr : 16'($urandom);
                body[0] = ($urandom_range(0, 9) != 0) ? CMD_UPLOAD : 8'($urandom);
                body[1] = addr[15:8];
                body[2] = addr[7:0];
                body[3] = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                body[4] = 8'($urandom);
                body[5] = 8'($urandom);
                send_rx(HDR_FIRST);
                if ($urandom_range(0, 3) == 0) send_rx(HDR_FIRST);
                send_rx(HDR_SECOND);
                send_rx(8'(len));
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < 4) send_pop();
                    send_rx((k < HEAD_KEEP) ? body[k] : 8'($urandom));
                end
            end else if (pick < 95) begin
                send_rx(HDR_FIRST);
                case ($urandom_range(0, 3))
                    0: begin
                        do b = 8'($urandom); while (b == HDR_FIRST || b == HDR_SECOND);
                        send_rx(b);
                    end
                    1: begin
                        send_rx(HDR_SECOND);
                        send_rx(8'h00);
                    end
                    2: begin
                        send_rx(HDR_SECOND);
                        send_rx(8'($urandom_range(MAX_FRAME_LEN + 1, 255)));
                    end
                    default: begin
                        // The frame is cut short, so following bytes land in its payload.
                        len = $urandom_range(HEAD_KEEP, 20);
                        send_rx(HDR_SECOND);
                        send_rx(8'(len));
                        repeat ($urandom_range(0, len - 1)) send_rx(8'($urandom));
                    end
                endcase
            end else begin
                send_rx(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        typed_result_t note;
        int i;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_BYTE;
        in_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.touch_vp_address = 16'h0000;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            note.typed  = DIRECTED_ROWS[i].typed;
            note.result = '{DIRECTED_ROWS[i].code_valid, DIRECTED_ROWS[i].touch_code};
            send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].rx_byte, note);
        end
        run_phase(200, 30);

        settle();
        cfg_write(16'hFFFF);
        run_phase(250, 10);

        // The long hold on the result side backs pops up into the input.
        settle();
        cfg_write(16'h5AA5);
        hold_request = 1'b1;
        run_phase(250, 50);

        settle();
        cfg_write(16'($urandom_range(1, 16'hFFFE)));
        run_phase(250, 30);

        settle();
        cfg_write(16'h0000);
        run_phase(200, 40);

        settle();
        cfg_write(16'($urandom));
        run_phase(150, 25);

        settle();
        if (mismatch_count == 0) begin
            $display("touch_frame_deframer_queue regression: pass");
        end else begin
            $display("touch_frame_deframer_queue regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("touch_frame_deframer_queue regression: fail");
        $finish;
    end

endmodule
